// ----- rtl/touch_average_and_calibrate_defines.svh -----
// ============================================================================
// Touch average and calibrate: assertion macros
// Shared assertion forms for the checker. Each macro expects signals named
// clk and rst_n in the scope where it is used.
// ============================================================================
`ifndef TOUCH_AVERAGE_AND_CALIBRATE_DEFINES_SVH
`define TOUCH_AVERAGE_AND_CALIBRATE_DEFINES_SVH

// The consequent must hold in the clock after the antecedent.
`define TAC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tac checker: next-cycle property failed");

// The consequent must hold in the same clock as the antecedent.
`define TAC_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tac checker: same-cycle property failed");

`endif

// ----- rtl/tac_pkg.sv -----
// ============================================================================
// Touch average and calibrate: shared package
// Field widths, register indexes, reset values and the types that travel
// between the front end, the queue and the calibration pipeline.
// ============================================================================
`default_nettype none

package tac_pkg;

    // Field widths fixed by the sample and register formats.
    localparam int SampleWidth   = 12;
    localparam int SumWidth      = 16;
    localparam int GainWidth     = 16;
    localparam int OffsetWidth   = 12;
    localparam int GainFracBits  = 12;
    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 16;

    // Defaults for the top-level parameters.
    localparam int DefaultSamplesPerReport = 10;
    localparam int DefaultScreenCoordBits  = 10;

    // Depth of the queue between the front end and the calibration pipeline.
    localparam int QueueDepth = 2;

    // Configuration register indexes.
    localparam logic [CfgIndexWidth-1:0] CfgGainX      = 3'd0;
    localparam logic [CfgIndexWidth-1:0] CfgOffsetX    = 3'd1;
    localparam logic [CfgIndexWidth-1:0] CfgGainY      = 3'd2;
    localparam logic [CfgIndexWidth-1:0] CfgOffsetY    = 3'd3;
    localparam logic [CfgIndexWidth-1:0] CfgContinuous = 3'd4;

    // Register reset values.
    localparam logic signed [GainWidth-1:0]   GainReset   = 16'sd512;
    localparam logic signed [OffsetWidth-1:0] OffsetReset = 12'sd0;

    // One finished burst: the two running sums.
    typedef struct packed {
        logic [SumWidth-1:0] sum_x;
        logic [SumWidth-1:0] sum_y;
    } sum_pair_t;

    // Calibration settings used by the back end.
    typedef struct packed {
        logic signed [GainWidth-1:0]   gain_x;
        logic signed [OffsetWidth-1:0] offset_x;
        logic signed [GainWidth-1:0]   gain_y;
        logic signed [OffsetWidth-1:0] offset_y;
    } cal_cfg_t;

    // Queue status seen by its producer and consumer.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

// ----- rtl/tac_if.sv -----
// ============================================================================
// Touch average and calibrate: channel interfaces
// Valid/ready channels for raw samples, calibrated coordinates and
// configuration writes.
// ============================================================================
`default_nettype none

// Raw converter sample channel.
interface tac_sample_if import tac_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   pen_down;
    logic [SampleWidth-1:0] x_sample;
    logic [SampleWidth-1:0] y_sample;

    modport source (output valid, output pen_down, output x_sample, output y_sample,
                    input ready);
    modport sink   (input valid, input pen_down, input x_sample, input y_sample,
                    output ready);
endinterface

// Calibrated coordinate channel.
interface tac_coord_if #(parameter int COORD_BITS = 10) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] x_pos;
    logic [COORD_BITS-1:0] y_pos;

    modport source (output valid, output x_pos, output y_pos, input ready);
    modport sink   (input valid, input x_pos, input y_pos, output ready);
endinterface

// Configuration write channel.
interface tac_cfg_if import tac_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CfgIndexWidth-1:0] index;
    logic [CfgDataWidth-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/tac_front.sv -----
// ============================================================================
// Touch average and calibrate: front end
// Accepts samples, tracks the press latch and the burst, and accumulates the
// burst sums. A finished burst is pushed into the queue.
// ============================================================================
`default_nettype none

module tac_front import tac_pkg::*; #(
    parameter int SAMPLES_PER_REPORT = DefaultSamplesPerReport
) (
    input  logic       clk,
    input  logic       rst_n,
    tac_sample_if.sink sample,
    input  logic       continuous_report,
    input  q_status_t  q_status,
    output logic       push,
    output sum_pair_t  push_data
);

    localparam int CountWidth = $clog2(SAMPLES_PER_REPORT + 1);
    localparam logic [CountWidth-1:0] BurstLoad = CountWidth'(SAMPLES_PER_REPORT);
    localparam logic [CountWidth-1:0] BurstLast = CountWidth'(1);

    logic [CountWidth-1:0] count_reg, count_next;
    logic                  latched_reg, latched_next;
    logic [SumWidth-1:0]   sum_x_reg, sum_x_next;
    logic [SumWidth-1:0]   sum_y_reg, sum_y_next;
    logic                  accept;
    logic                  latched_eff;
    logic [SumWidth-1:0]   sum_x_add;
    logic [SumWidth-1:0]   sum_y_add;

    // Stall the sample channel only while the queue has no room.
    assign sample.ready = !q_status.full;
    assign accept       = sample.valid && sample.ready;

    assign sum_x_add = sum_x_reg + SumWidth'(sample.x_sample);
    assign sum_y_add = sum_y_reg + SumWidth'(sample.y_sample);
    assign push_data = '{sum_x: sum_x_add, sum_y: sum_y_add};

    // In continuous mode the latch is dropped on every sample outside a burst.
    assign latched_eff = continuous_report ? 1'b0 : latched_reg;

    // Burst control and accumulation.
    always_comb
    begin
        count_next   = count_reg;
        latched_next = latched_reg;
        sum_x_next   = sum_x_reg;
        sum_y_next   = sum_y_reg;
        push         = 1'b0;
        if (accept)
        begin
            if (count_reg != '0)
            begin
                sum_x_next = sum_x_add;
                sum_y_next = sum_y_add;
                count_next = count_reg - BurstLast;
                push       = (count_reg == BurstLast);
            end
            else if (sample.pen_down && !latched_eff)
            begin
                latched_next = 1'b1;
                count_next   = BurstLoad;
                sum_x_next   = '0;
                sum_y_next   = '0;
            end
            else if (!sample.pen_down)
            begin
                latched_next = 1'b0;
            end
            else
            begin
                latched_next = latched_eff;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            latched_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            latched_reg <= latched_next;
        end
    end

    // Running sums.
    always_ff @(posedge clk)
    begin
        sum_x_reg <= sum_x_next;
        sum_y_reg <= sum_y_next;
    end

endmodule

`default_nettype wire

// ----- rtl/tac_queue.sv -----
// ============================================================================
// Touch average and calibrate: burst queue
// Short first-in first-out queue of finished burst sums between the front
// end and the calibration pipeline.
// ============================================================================
`default_nettype none

module tac_queue import tac_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  sum_pair_t push_data,
    input  logic      pop,
    output sum_pair_t head,
    output q_status_t status
);

    localparam int PtrWidth   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CountWidth = $clog2(QueueDepth + 1);
    localparam logic [PtrWidth-1:0]   PtrLast  = PtrWidth'(QueueDepth - 1);
    localparam logic [CountWidth-1:0] CountMax = CountWidth'(QueueDepth);

    sum_pair_t             entry_reg [QueueDepth];
    logic [PtrWidth-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CountWidth-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CountMax);
    assign status.empty = (count_reg == '0);
    assign head         = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + PtrWidth'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + PtrWidth'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CountWidth'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CountWidth'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tac_back.sv -----
// ============================================================================
// Touch average and calibrate: calibration pipeline
// Three stages: average by reciprocal multiply, gain multiply, then floor,
// offset and saturation into the output register.
// ============================================================================
`default_nettype none

module tac_back import tac_pkg::*; #(
    parameter int SAMPLES_PER_REPORT = DefaultSamplesPerReport,
    parameter int SCREEN_COORD_BITS  = DefaultScreenCoordBits
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cal_cfg_t    cal_cfg,
    input  sum_pair_t   head,
    input  q_status_t   q_status,
    output logic        pop,
    tac_coord_if.source coord
);

    // Exact truncating divide by the burst length for any 16-bit sum:
    // avg = (sum * ceil(2^S / N)) >> S with S = SumWidth + ceil(log2 N).
    localparam int DivShift    = SumWidth + $clog2(SAMPLES_PER_REPORT);
    localparam int DivMulWidth = SumWidth + 1;
    localparam int QuotWidth   = DivShift + SumWidth;
    localparam logic [DivMulWidth-1:0] DivMul =
        DivMulWidth'(((64'd1 << DivShift) + 64'(SAMPLES_PER_REPORT) - 64'd1)
                     / 64'(SAMPLES_PER_REPORT));

    localparam int ProdWidth  = SumWidth + 1 + GainWidth;
    localparam int FloorWidth = ProdWidth - GainFracBits;
    localparam logic signed [FloorWidth:0] CoordMax =
        (FloorWidth + 1)'((1 << SCREEN_COORD_BITS) - 1);

    logic                          en;
    logic                          v1_reg, v2_reg, v3_reg;
    logic [QuotWidth-1:0]          quot_x, quot_y;
    logic [SumWidth-1:0]           avg_x_reg, avg_y_reg;
    logic signed [SumWidth:0]      avg_x_s, avg_y_s;
    logic signed [ProdWidth-1:0]   prod_x_next, prod_y_next;
    logic signed [ProdWidth-1:0]   prod_x_reg, prod_y_reg;
    logic [SCREEN_COORD_BITS-1:0]  x_pos_next, y_pos_next;
    logic [SCREEN_COORD_BITS-1:0]  x_pos_reg, y_pos_reg;

    // Floor by the gain fraction, add the offset and clamp to the screen.
    function automatic logic [SCREEN_COORD_BITS-1:0] scale_out(
        input logic signed [ProdWidth-1:0]   prod,
        input logic signed [OffsetWidth-1:0] offset
    );
        logic signed [FloorWidth-1:0] floored;
        logic signed [FloorWidth:0]   value;
        logic [SCREEN_COORD_BITS-1:0] result;
        floored = $signed(prod[ProdWidth-1:GainFracBits]);
        value   = (FloorWidth + 1)'(floored) + (FloorWidth + 1)'(offset);
        if (value < 0)
        begin
            result = '0;
        end
        else if (value > CoordMax)
        begin
            result = CoordMax[SCREEN_COORD_BITS-1:0];
        end
        else
        begin
            result = value[SCREEN_COORD_BITS-1:0];
        end
        return result;
    endfunction

    // The whole pipeline advances unless the output holds an untaken result.
    assign en  = !v3_reg || coord.ready;
    assign pop = en && !q_status.empty;

    // Stage 1 inputs: reciprocal multiply of the queued sums.
    assign quot_x = QuotWidth'(head.sum_x) * QuotWidth'(DivMul);
    assign quot_y = QuotWidth'(head.sum_y) * QuotWidth'(DivMul);

    // Stage 2 inputs: signed gain multiply.
    assign avg_x_s     = $signed({1'b0, avg_x_reg});
    assign avg_y_s     = $signed({1'b0, avg_y_reg});
    assign prod_x_next = avg_x_s * cal_cfg.gain_x;
    assign prod_y_next = avg_y_s * cal_cfg.gain_y;

    // Stage 3 inputs: floor, offset and saturation.
    assign x_pos_next = scale_out(prod_x_reg, cal_cfg.offset_x);
    assign y_pos_next = scale_out(prod_y_reg, cal_cfg.offset_y);

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= pop;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage data.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            avg_x_reg  <= quot_x[DivShift +: SumWidth];
            avg_y_reg  <= quot_y[DivShift +: SumWidth];
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            x_pos_reg  <= x_pos_next;
            y_pos_reg  <= y_pos_next;
        end
    end

    assign coord.valid = v3_reg;
    assign coord.x_pos = x_pos_reg;
    assign coord.y_pos = y_pos_reg;

endmodule

`default_nettype wire

// ----- rtl/touch_average_and_calibrate.sv -----
// One raw sample pair is taken per clock cycle; the sample channel stalls only
// while the two-entry burst queue is full, which happens only when results are
// left untaken at the output. A pen-down sample with no press latched opens a
// burst; the next SAMPLES_PER_REPORT samples are summed and the pair of sums
// enters a three-stage calibration pipeline (reciprocal divide, Q3.12 gain
// multiply, floor plus offset with saturation); each pair of sums passes the
// burst queue and then the average, product and output registers. An output
// stall holds the whole calibration pipeline. The configuration port is always
// ready and takes one register write per cycle; write it only while no burst
// is open or in flight.
// ============================================================================
// Touch average and calibrate: top level
// Register file, front end, burst queue and calibration pipeline.
// ============================================================================
`default_nettype none

module touch_average_and_calibrate import tac_pkg::*; #(
    parameter int SAMPLES_PER_REPORT = DefaultSamplesPerReport,
    parameter int SCREEN_COORD_BITS  = DefaultScreenCoordBits
) (
    input  logic        clk,
    input  logic        rst_n,
    tac_sample_if.sink  sample,
    tac_coord_if.source coord,
    tac_cfg_if.sink     cfg
);

    cal_cfg_t  cal_cfg_reg, cal_cfg_next;
    logic      continuous_reg, continuous_next;
    logic      cfg_write;
    logic      push;
    logic      pop;
    sum_pair_t push_data;
    sum_pair_t head;
    q_status_t q_status;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    // Register decode; unknown indexes are ignored.
    always_comb
    begin
        cal_cfg_next    = cal_cfg_reg;
        continuous_next = continuous_reg;
        if (cfg_write)
        begin
            case (cfg.index)
                CfgGainX:      cal_cfg_next.gain_x   = $signed(cfg.data[GainWidth-1:0]);
                CfgOffsetX:    cal_cfg_next.offset_x = $signed(cfg.data[OffsetWidth-1:0]);
                CfgGainY:      cal_cfg_next.gain_y   = $signed(cfg.data[GainWidth-1:0]);
                CfgOffsetY:    cal_cfg_next.offset_y = $signed(cfg.data[OffsetWidth-1:0]);
                CfgContinuous: continuous_next       = cfg.data[0];
                default:       continuous_next       = continuous_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_cfg_reg.gain_x   <= GainReset;
            cal_cfg_reg.offset_x <= OffsetReset;
            cal_cfg_reg.gain_y   <= GainReset;
            cal_cfg_reg.offset_y <= OffsetReset;
            continuous_reg       <= 1'b0;
        end
        else
        begin
            cal_cfg_reg    <= cal_cfg_next;
            continuous_reg <= continuous_next;
        end
    end

    // Sample intake and burst accumulation.
    tac_front #(
        .SAMPLES_PER_REPORT (SAMPLES_PER_REPORT)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .sample            (sample),
        .continuous_report (continuous_reg),
        .q_status          (q_status),
        .push              (push),
        .push_data         (push_data)
    );

    // Finished bursts waiting for calibration.
    tac_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    // Calibration pipeline and output register.
    tac_back #(
        .SAMPLES_PER_REPORT (SAMPLES_PER_REPORT),
        .SCREEN_COORD_BITS  (SCREEN_COORD_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cal_cfg  (cal_cfg_reg),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .coord    (coord)
    );

endmodule

`default_nettype wire

// ----- rtl/tac_checker.sv -----
// ============================================================================
// Touch average and calibrate: port checker
// Watches the top-level ports for output hold and for sample back-pressure
// that only follows an output stall.
// ============================================================================
`default_nettype none

`include "touch_average_and_calibrate_defines.svh"

module tac_checker #(
    parameter int COORD_BITS = 10
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  sample_ready,
    input logic                  coord_valid,
    input logic                  coord_ready,
    input logic [COORD_BITS-1:0] x_pos,
    input logic [COORD_BITS-1:0] y_pos
);

    logic coord_stall;

    assign coord_stall = coord_valid && !coord_ready;

    // A stalled result stays offered.
    `TAC_ASSERT_NEXT(a_coord_hold, coord_stall, coord_valid)

    // A stalled result keeps its coordinates.
    `TAC_ASSERT_NEXT(a_coord_stable, coord_stall, $stable(x_pos) && $stable(y_pos))

    // The sample side only stalls after the result side was stalled.
    `TAC_ASSERT_SAME(a_sample_stall_cause, !sample_ready, $past(coord_stall))

endmodule

bind touch_average_and_calibrate tac_checker #(
    .COORD_BITS (SCREEN_COORD_BITS)
) u_tac_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_ready (sample.ready),
    .coord_valid  (coord.valid),
    .coord_ready  (coord.ready),
    .x_pos        (coord.x_pos),
    .y_pos        (coord.y_pos)
);

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Touch average and calibrate: testbench
// Drives sample bursts and register writes into the block, predicts each
// calibrated coordinate pair in a scoreboard and compares every transfer at
// the output, with random gaps, output stalls and one long output hold-off.
// ============================================================================

module tb;
    import tac_pkg::*;

    localparam int     CoordBits      = DefaultScreenCoordBits;
    localparam int     BurstLength    = DefaultSamplesPerReport;
    localparam longint CoordMax       = (longint'(1) << CoordBits) - 1;
    localparam int     PipeSlack      = 8;
    localparam int     WatchdogLimit  = 2000;
    localparam int     PhaseCount     = 10;
    localparam int     ItemsPerPhase  = 112;
    localparam int     HoldOffCycles  = 300;
    localparam int     ReportLimit    = 10;

    typedef struct packed {
        logic [CoordBits-1:0] x;
        logic [CoordBits-1:0] y;
    } screen_point_t;

    // Tracks burst state and calibration settings, and holds the coordinate
    // pairs that the block still owes.
    class coord_scoreboard;
        logic signed [GainWidth-1:0]   gain_x;
        logic signed [OffsetWidth-1:0] offset_x;
        logic signed [GainWidth-1:0]   gain_y;
        logic signed [OffsetWidth-1:0] offset_y;
        bit                            continuous;
        int unsigned                   burst_left;
        logic [SumWidth-1:0]           sum_x;
        logic [SumWidth-1:0]           sum_y;
        bit                            latched;
        screen_point_t                 owed_points[$];
        int                            mismatches;

        function new();
            gain_x     = GainReset;
            offset_x   = OffsetReset;
            gain_y     = GainReset;
            offset_y   = OffsetReset;
            continuous = 1'b0;
            burst_left = 0;
            sum_x      = '0;
            sum_y      = '0;
            latched    = 1'b0;
            mismatches = 0;
        endfunction

        // Register write; indexes past the last register are ignored.
        function void write_reg(logic [CfgIndexWidth-1:0] index,
                                logic [CfgDataWidth-1:0] data);
            case (index)
                CfgGainX:      gain_x = data;
                CfgOffsetX:    offset_x = data[OffsetWidth-1:0];
                CfgGainY:      gain_y = data;
                CfgOffsetY:    offset_y = data[OffsetWidth-1:0];
                CfgContinuous: continuous = data[0];
                default: ;
            endcase
        endfunction

        // Average, Q3.12 scale floored toward minus infinity, offset, clamp.
        function logic [CoordBits-1:0] calibrate_axis(logic [SumWidth-1:0] sum,
                                                      logic signed [GainWidth-1:0] gain,
                                                      logic signed [OffsetWidth-1:0] offset);
            longint mean;
            longint scaled;
            longint pixel;
            mean   = longint'(sum) / BurstLength;
            scaled = mean * longint'(gain);
            pixel  = (scaled >>> GainFracBits) + longint'(offset);
            if (pixel < 0)
                pixel = 0;
            else if (pixel > CoordMax)
                pixel = CoordMax;
            return pixel[CoordBits-1:0];
        endfunction

        // Notes one accepted sample and queues the pair it completes, if any.
        function void note_sample(bit pen, logic [SampleWidth-1:0] x,
                                  logic [SampleWidth-1:0] y);
            screen_point_t point;
            if (burst_left != 0) begin
                sum_x = sum_x + SumWidth'(x);
                sum_y = sum_y + SumWidth'(y);
                burst_left--;
                if (burst_left == 0) begin
                    point.x = calibrate_axis(sum_x, gain_x, offset_x);
                    point.y = calibrate_axis(sum_y, gain_y, offset_y);
                    owed_points.push_back(point);
                end
                return;
            end
            if (continuous)
                latched = 1'b0;
            if (pen && !latched) begin
                latched    = 1'b1;
                burst_left = BurstLength;
                sum_x      = '0;
                sum_y      = '0;
            end else if (!pen) begin
                latched = 1'b0;
            end
        endfunction

        // Compares one output transfer with the oldest owed pair.
        function void check_coord(logic [CoordBits-1:0] x, logic [CoordBits-1:0] y);
            screen_point_t want;
            if (owed_points.size() == 0) begin
                mismatches++;
                if (mismatches <= ReportLimit)
                    $display("%0t: unexpected coordinate x=%0d y=%0d", $time, x, y);
                return;
            end
            want = owed_points.pop_front();
            if (x !== want.x) begin
                mismatches++;
                if (mismatches <= ReportLimit)
                    $display("%0t: x_pos expected %0d, got %0d", $time, want.x, x);
            end
            if (y !== want.y) begin
                mismatches++;
                if (mismatches <= ReportLimit)
                    $display("%0t: y_pos expected %0d, got %0d", $time, want.y, y);
            end
        endfunction

        function int pending();
            return owed_points.size();
        endfunction

        function bit burst_open();
            return burst_left != 0;
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    tac_sample_if                         sample_ch ();
    tac_coord_if #(.COORD_BITS(CoordBits)) coord_ch ();
    tac_cfg_if                            cfg_ch ();

    coord_scoreboard sb;
    bit              src_gaps;
    bit              sink_stalls;
    int              hold_cycles;
    int              idle_cycles;

    touch_average_and_calibrate DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .sample(sample_ch),
        .coord (coord_ch),
        .cfg   (cfg_ch)
    );

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Ends the run when no transfer happens on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end else if ((sample_ch.valid && sample_ch.ready) ||
                     (coord_ch.valid && coord_ch.ready) ||
                     (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit) begin
                $display("%0t: no transfer for %0d cycles", $time, WatchdogLimit);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Output side: random stalls, plus one long hold-off when requested.
    initial
    begin
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            int stall;
            stall = sink_stalls ? $urandom_range(0, 5) : 0;
            if (hold_cycles > 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0) begin
                coord_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            coord_ch.ready <= 1'b1;
            @(posedge clk);
            while (!coord_ch.valid) @(posedge clk);
            sb.check_coord(coord_ch.x_pos, coord_ch.y_pos);
            @(negedge clk);
        end
    end

    // One sample transfer; entered and left at a falling edge, valid left high.
    task automatic send_sample(input bit pen, input logic [SampleWidth-1:0] x,
                               input logic [SampleWidth-1:0] y);
        int gap;
        gap = src_gaps ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid    <= 1'b1;
        sample_ch.pen_down <= pen;
        sample_ch.x_sample <= x;
        sample_ch.y_sample <= y;
        @(posedge clk);
        while (!sample_ch.ready) @(posedge clk);
        sb.note_sample(pen, x, y);
        @(negedge clk);
    endtask

    // One register write transfer; valid is left high for a following write.
    task automatic write_cfg(input logic [CfgIndexWidth-1:0] index,
                             input logic [CfgDataWidth-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        sb.write_reg(index, data);
        @(negedge clk);
    endtask

    // Raw readings: full range, low values, the two rails, or near the top.
    function automatic logic [SampleWidth-1:0] pick_reading();
        case ($urandom_range(0, 3))
            0:       return SampleWidth'($urandom_range(0, 4095));
            1:       return SampleWidth'($urandom_range(0, 127));
            2:       return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            default: return SampleWidth'($urandom_range(4000, 4095));
        endcase
    endfunction

    // Finishes an open burst so that the block has nothing in flight.
    task automatic close_burst();
        while (sb.burst_open())
            send_sample(1'($urandom_range(0, 1)), pick_reading(), pick_reading());
    endtask

    // Stops offering samples and waits until every owed pair has arrived.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (PipeSlack) @(negedge clk);
    endtask

    // Stimulus and end of run.
    initial
    begin
        logic signed [GainWidth-1:0]   gx;
        logic signed [GainWidth-1:0]   gy;
        logic signed [OffsetWidth-1:0] ox;
        logic signed [OffsetWidth-1:0] oy;
        bit                            mode;
        int                            pen_pct;

        sb                 = new();
        src_gaps           = 1'b0;
        sink_stalls        = 1'b0;
        hold_cycles        = 0;
        rst_n              = 1'b0;
        sample_ch.valid    = 1'b0;
        sample_ch.pen_down = 1'b0;
        sample_ch.x_sample = '0;
        sample_ch.y_sample = '0;
        coord_ch.ready     = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = '0;
        cfg_ch.data        = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Press at reset settings: the opening sample is dropped, and the pen
        // level inside the burst does not matter.
        send_sample(1'b1, 12'hFFF, 12'hFFF);
        for (int i = 0; i < BurstLength; i++)
            send_sample(i[0], 12'hFFF, 12'h000);
        // Held pen reports nothing more; release, then a new press.
        send_sample(1'b1, 12'h555, 12'hAAA);
        send_sample(1'b0, 12'hAAA, 12'h555);
        send_sample(1'b0, 12'h000, 12'hFFF);
        send_sample(1'b1, 12'h000, 12'h000);
        for (int i = 0; i < BurstLength; i++)
            send_sample(~i[0], i[0] ? 12'hAAA : 12'h555, 12'hFFF);

        for (int phase = 0; phase < PhaseCount; phase++)
        begin
            close_burst();
            settle();

            case (phase)
                0: begin gx = 16'sh7FFF; gy = 16'sh7FFF; ox = 12'sh7FF; oy = 12'sh7FF; mode = 1'b1; end
                1: begin gx = 16'sh8000; gy = 16'sh8000; ox = 12'sh800; oy = 12'sh800; mode = 1'b0; end
                2: begin gx = 16'sd4096; gy = 16'sd4096; ox = 12'sd0;   oy = 12'sd0;   mode = 1'b0; end
                3: begin gx = -16'sd4096; gy = -16'sd2048; ox = 12'sd1023; oy = 12'sd1023; mode = 1'b1; end
                default:
                begin
                    gx   = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 12288) - 4096);
                    gy   = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 12288) - 4096);
                    ox   = 12'($urandom);
                    oy   = 12'($urandom);
                    mode = 1'($urandom_range(0, 1));
                end
            endcase

            // Upper data bits beyond each register's width are don't-care.
            write_cfg(CfgGainX, gx);
            write_cfg(CfgOffsetX, {4'($urandom), ox});
            write_cfg(CfgGainY, gy);
            write_cfg(CfgOffsetY, {4'($urandom), oy});
            write_cfg(CfgContinuous, {15'($urandom), mode});
            write_cfg(3'($urandom_range(5, 7)), 16'($urandom));
            cfg_ch.valid <= 1'b0;

            src_gaps    = phase[0];
            sink_stalls = phase[1];
            pen_pct     = $urandom_range(50, 95);

            // Output held off while the pen stays down back to back, so the
            // burst queue fills and the input stalls.
            if (phase == 3) begin
                src_gaps    = 1'b0;
                hold_cycles = HoldOffCycles;
                repeat (120) send_sample(1'b1, pick_reading(), pick_reading());
            end

            repeat (ItemsPerPhase)
                send_sample($urandom_range(0, 99) < pen_pct, pick_reading(), pick_reading());
        end

        settle();
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
